// ----- src/rbfc_pkg.sv -----
// ----------------------------------------------------------------------------
// rbfc_pkg
// Shared widths, reset values and register map of the red blob frame centre.
// ----------------------------------------------------------------------------
package rbfc_pkg;

  // Default geometry, handed to the core as parameter defaults
  localparam int unsigned CoordBitsDefault = 10;
  localparam int unsigned CountBitsDefault = 20;

  // Fixed field widths
  localparam int unsigned LevelBits = 8;
  localparam int unsigned RatioBits = 6;
  localparam int unsigned StampBits = 16;
  localparam int unsigned MulBits   = RatioBits + LevelBits;

  // Red test: 10 * red against ratio (tenths) * channel
  localparam logic [3:0] RedScale = 4'd10;

  // Configuration register reset values
  localparam logic [RatioBits-1:0] RatioReset = 6'd14;
  localparam int unsigned          MinReset   = 100;

  // APB register map
  localparam int unsigned ApbDataBits = 32;
  localparam int unsigned ApbAddrBits = 3;

  typedef enum logic [0:0] {
    REG_RED_RATIO = 1'b0,
    REG_MIN_RED   = 1'b1
  } reg_idx_e;

endpackage

// ----- src/red_blob_frame_centre_core.sv -----
// ----------------------------------------------------------------------------
// red_blob_frame_centre_core
// Red pixel classifier, counter and first/last blob centre per frame.
// ----------------------------------------------------------------------------
// The core takes one pixel beat per cycle in raster order and classifies it as
// red when 10*red exceeds both ratio*green and ratio*blue (ratio in tenths,
// register red_ratio_tenths, 14 after reset). It counts red pixels with a
// saturating counter and keeps the coordinates of the first red pixel of the
// frame and of the latest one after it; at frame end only the count is
// cleared, not the coordinates. The beat flagged by s_axis_tlast closes the
// frame: it is classified first, then one result beat is issued carrying the
// day flag (count above min_red_pixels), the midpoint centre of the first and
// latest red pixels, the frame time of that beat and the frame's red count.
// Other pixel beats produce no output. Throughput is one pixel per cycle: a
// beat sits in the input register, where it is classified and folded into
// the frame state, and a frame result then waits in the output register
// until taken. Only an end-of-frame beat can be held up by a stalled output;
// pixel beats keep flowing while a result waits. Configuration registers are
// on an APB port (red_ratio_tenths at 0x0, min_red_pixels at 0x4), pready is
// tied high, and they must only be written while the core is idle.
// ----------------------------------------------------------------------------
module red_blob_frame_centre_core #(
  parameter int unsigned COORD_BITS = rbfc_pkg::CoordBitsDefault,
  parameter int unsigned COUNT_BITS = rbfc_pkg::CountBitsDefault,
  localparam int unsigned InBits  = 2 * COORD_BITS + 3 * rbfc_pkg::LevelBits
                                    + rbfc_pkg::StampBits,
  localparam int unsigned InW     = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits = 1 + 2 * COORD_BITS + rbfc_pkg::StampBits
                                    + COUNT_BITS,
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // Pixel stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low to high: pixel_col, pixel_row, red_level, green_level,
  // blue_level, frame_time, zero fill
  input  logic [InW-1:0]                      s_axis_tdata,
  input  logic                                s_axis_tlast,    // frame_end

  // Frame result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low to high: sun_visible, centre_col, centre_row, stamp,
  // red_total, zero fill
  output logic [OutW-1:0]                     m_axis_tdata,

  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rbfc_pkg::ApbAddrBits-1:0]    paddr,
  input  logic [rbfc_pkg::ApbDataBits-1:0]    pwdata,
  output logic [rbfc_pkg::ApbDataBits-1:0]    prdata,
  output logic                                pready
);

  localparam int unsigned LB = rbfc_pkg::LevelBits;
  localparam int unsigned SB = rbfc_pkg::StampBits;
  localparam int unsigned RB = rbfc_pkg::RatioBits;
  localparam int unsigned MB = rbfc_pkg::MulBits;

  localparam int unsigned RowLo   = COORD_BITS;
  localparam int unsigned RedLo   = 2 * COORD_BITS;
  localparam int unsigned GreenLo = RedLo + LB;
  localparam int unsigned BlueLo  = GreenLo + LB;
  localparam int unsigned TimeLo  = BlueLo + LB;

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RB-1:0]         ratio_q;
  logic [COUNT_BITS-1:0] min_red_q;
  logic                  cfg_wr;
  rbfc_pkg::reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = rbfc_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q   <= rbfc_pkg::RatioReset;
      min_red_q <= COUNT_BITS'(rbfc_pkg::MinReset);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rbfc_pkg::REG_RED_RATIO: ratio_q   <= pwdata[RB-1:0];
        rbfc_pkg::REG_MIN_RED:   min_red_q <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      rbfc_pkg::REG_RED_RATIO: prdata = rbfc_pkg::ApbDataBits'(ratio_q);
      rbfc_pkg::REG_MIN_RED:   prdata = rbfc_pkg::ApbDataBits'(min_red_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                  in_valid_q;
  logic [COORD_BITS-1:0] in_col_q, in_row_q;
  logic [LB-1:0]         in_red_q, in_green_q, in_blue_q;
  logic                  in_last_q;
  logic [SB-1:0]         in_time_q;
  logic                  in_adv;
  logic                  s_accept;

  // A held pixel moves on unless it closes a frame and the output is still full
  assign in_adv        = in_valid_q & (~in_last_q | ~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | in_adv;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_col_q   <= s_axis_tdata[COORD_BITS-1:0];
      in_row_q   <= s_axis_tdata[RowLo +: COORD_BITS];
      in_red_q   <= s_axis_tdata[RedLo +: LB];
      in_green_q <= s_axis_tdata[GreenLo +: LB];
      in_blue_q  <= s_axis_tdata[BlueLo +: LB];
      in_time_q  <= s_axis_tdata[TimeLo +: SB];
      in_last_q  <= s_axis_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Classify and fold into frame state
  // --------------------------------------------------------------------------
  logic [MB-1:0] red_scaled, green_scaled, blue_scaled;
  logic          is_red;

  assign red_scaled   = MB'(in_red_q) * MB'(rbfc_pkg::RedScale);
  assign green_scaled = MB'(ratio_q) * MB'(in_green_q);
  assign blue_scaled  = MB'(ratio_q) * MB'(in_blue_q);
  assign is_red       = (red_scaled > green_scaled) && (red_scaled > blue_scaled);

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COORD_BITS-1:0] first_col_q, first_col_d, first_row_q, first_row_d;
  logic [COORD_BITS-1:0] last_col_q, last_col_d, last_row_q, last_row_d;

  always_comb begin
    count_d     = count_q;
    first_col_d = first_col_q;
    first_row_d = first_row_q;
    last_col_d  = last_col_q;
    last_row_d  = last_row_q;
    if (is_red) begin
      // First red pixel of the frame opens the blob, later ones extend it
      if (count_q == '0) begin
        first_col_d = in_col_q;
        first_row_d = in_row_q;
      end else begin
        last_col_d = in_col_q;
        last_row_d = in_row_q;
      end
      if (count_q != CountMax) begin
        count_d = count_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      first_col_q <= '0;
      first_row_q <= '0;
      last_col_q  <= '0;
      last_row_q  <= '0;
    end else if (in_adv) begin
      // Clear the count at frame end; coordinates carry over
      count_q     <= in_last_q ? '0 : count_d;
      first_col_q <= first_col_d;
      first_row_q <= first_row_d;
      last_col_q  <= last_col_d;
      last_row_q  <= last_row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Frame result
  // --------------------------------------------------------------------------
  // start + (end - start) / 2 with the halving rounded toward zero
  function automatic logic [COORD_BITS-1:0] midpoint(
    input logic [COORD_BITS-1:0] start,
    input logic [COORD_BITS-1:0] stop
  );
    logic [COORD_BITS:0] diff;
    logic [COORD_BITS:0] half;
    logic [COORD_BITS:0] sum;
    diff = {1'b0, stop} - {1'b0, start};
    half = {diff[COORD_BITS], diff[COORD_BITS:1]}
           + {{COORD_BITS{1'b0}}, diff[COORD_BITS] & diff[0]};
    sum  = {1'b0, start} + half;
    return sum[COORD_BITS-1:0];
  endfunction

  logic                  out_valid_q;
  logic                  out_sun_q;
  logic [COORD_BITS-1:0] out_col_q, out_row_q;
  logic [SB-1:0]         out_stamp_q;
  logic [COUNT_BITS-1:0] out_total_q;
  logic                  out_load;

  assign out_load = in_adv & in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sun_q   <= count_d > min_red_q;
      out_col_q   <= midpoint(first_col_d, last_col_d);
      out_row_q   <= midpoint(first_row_d, last_row_d);
      out_stamp_q <= in_time_q;
      out_total_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_total_q, out_stamp_q, out_row_q, out_col_q, out_sun_q});

endmodule
